>>> hw/rtl/wdwr_pkg.sv
// ----------------------------------------------------------------------------
// wdwr_pkg: shared types and codes for the weighted draw block
// Request and result payloads, command and status codes, widths.
// ----------------------------------------------------------------------------
package wdwr_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = 6;
	localparam int WEIGHT_W    = 8;
	localparam int CNT_W       = 7;
	localparam int TOTAL_W     = 14;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
	localparam logic [CNT_W-1:0]   ENTRIES_MAX = CNT_W'(MAX_ENTRIES);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_ROUND = 2'd1;
	localparam logic [1:0] CMD_DRAW  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_COUNT_HIGH = 2'd1;
	localparam logic [1:0] ST_NONE_DUE   = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [IDX_W-1:0]    entry_index;
		logic [WEIGHT_W-1:0] entry_weight;
		logic [CNT_W-1:0]    draw_count;
		logic [TOTAL_W-1:0]  random_value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] selected_index;
		logic [CNT_W-1:0] draws_remaining;
	} rsp_t;

endpackage

>>> hw/rtl/weighted_draw_without_replacement.sv
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement: roulette wheel draw without replacement
// Weight table in a synchronous RAM, walked one entry per cycle.
// ----------------------------------------------------------------------------
// Weight writes, refused rounds, idle draws, in-order draws, no-ops and any round or
//   draw with nothing in use answer in the cycle after the request; a round start
//   walks all n entries in use to sum them, a random draw walks until it hits entry k.
// Throughput: one request per response; busy holds off requests during a walk.
// Done pulses one cycle; the receiver cannot stall.
// Reset clears control state, removal mask and totals; weights stay undefined.
module weighted_draw_without_replacement
	import wdwr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             start,
	input  req_t             req,
	output logic             busy,
	output logic             done,
	output rsp_t             rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUM  = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	logic [WEIGHT_W-1:0]    mem [MAX_ENTRIES];
	logic [WEIGHT_W-1:0]    rd_data_s1;

	logic [CNT_W-1:0]       cfg_q;
	logic [1:0]             state_q;
	logic [IDX_W-1:0]       rd_addr_q;
	logic                   issue_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TOTAL_W-1:0]     acc_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [CNT_W-1:0]       pending_q;
	logic                   take_all_q;
	logic [IDX_W-1:0]       next_q;
	logic [MAX_ENTRIES-1:0] removed_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic [CNT_W-1:0]   n_use;
	logic               accept;
	logic               last_s1;
	logic [TOTAL_W:0]   sum_ext;
	logic [TOTAL_W-1:0] sum_sat;
	logic [TOTAL_W-1:0] w_ext;
	logic [CNT_W-1:0]   pend_dec;

	assign n_use    = (cfg_q > ENTRIES_MAX) ? ENTRIES_MAX : cfg_q;
	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign last_s1  = ({1'b0, idx_s1} == (n_use - CNT_W'(1)));
	assign w_ext    = TOTAL_W'(rd_data_s1);
	assign sum_ext  = {1'b0, acc_q} + {1'b0, w_ext};
	assign sum_sat  = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
	assign pend_dec = pending_q - CNT_W'(1);
	assign done     = done_q;
	assign rsp      = rsp_q;

	// weight RAM: writes only while idle; read every cycle, data used only during a walk
	always_ff @(posedge clk) begin
		if (accept && req.cmd == CMD_WRITE && {1'b0, req.entry_index} < n_use) begin
			mem[req.entry_index] <= req.entry_weight;
		end
		rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= '0;
			state_q    <= S_IDLE;
			rd_addr_q  <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			acc_q      <= '0;
			total_q    <= '0;
			pending_q  <= '0;
			take_all_q <= 1'b0;
			next_q     <= '0;
			removed_q  <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end

			// read issue stage of the walk
			if (state_q != S_IDLE && issue_q) begin
				vld_s1 <= 1'b1;
				idx_s1 <= rd_addr_q;
				if ({1'b0, rd_addr_q} == n_use - CNT_W'(1)) begin
					issue_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
			end else begin
				vld_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_addr_q <= '0;
						unique case (req.cmd)
							CMD_WRITE: begin
								done_q <= 1'b1;
								rsp_q  <= '{status: ({1'b0, req.entry_index} < n_use) ?
									ST_OK : ST_BAD_INDEX, selected_index: '0,
									draws_remaining: pending_q};
							end
							CMD_ROUND: begin
								if (req.draw_count > n_use) begin
									pending_q  <= '0;
									take_all_q <= 1'b0;
									done_q     <= 1'b1;
									rsp_q      <= '{status: ST_COUNT_HIGH, selected_index: '0,
										draws_remaining: '0};
								end else begin
									removed_q  <= '0;
									pending_q  <= req.draw_count;
									next_q     <= '0;
									take_all_q <= (req.draw_count == n_use);
									acc_q      <= '0;
									if (n_use == '0) begin
										total_q <= '0;
										done_q  <= 1'b1;
										rsp_q   <= '{status: ST_OK, selected_index: '0,
											draws_remaining: req.draw_count};
									end else begin
										issue_q <= 1'b1;
										state_q <= S_SUM;
									end
								end
							end
							CMD_DRAW: begin
								if (pending_q == '0) begin
									done_q <= 1'b1;
									rsp_q  <= '{status: ST_NONE_DUE, selected_index: '0,
										draws_remaining: '0};
								end else begin
									pending_q <= pend_dec;
									if (take_all_q) begin
										next_q <= next_q + IDX_W'(1);
										done_q <= 1'b1;
										if ({1'b0, next_q} >= n_use) begin
											rsp_q <= '{status: ST_BAD_INDEX, selected_index: '0,
												draws_remaining: pend_dec};
										end else begin
											removed_q[next_q] <= 1'b1;
											rsp_q <= '{status: ST_OK, selected_index: next_q,
												draws_remaining: pend_dec};
										end
									end else if (n_use == '0) begin
										done_q <= 1'b1;
										rsp_q  <= '{status: ST_BAD_INDEX, selected_index: '0,
											draws_remaining: pend_dec};
									end else begin
										acc_q   <= (req.random_value > total_q) ?
											total_q : req.random_value;
										issue_q <= 1'b1;
										state_q <= S_WALK;
									end
								end
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= '{status: ST_OK, selected_index: '0,
									draws_remaining: pending_q};
							end
						endcase
					end
				end
				S_SUM: begin
					if (vld_s1) begin
						acc_q <= sum_sat;
						if (last_s1) begin
							total_q <= sum_sat;
							issue_q <= 1'b0;
							vld_s1  <= 1'b0;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							rsp_q   <= '{status: ST_OK, selected_index: '0,
								draws_remaining: pending_q};
						end
					end
				end
				S_WALK: begin
					if (vld_s1) begin
						if (!removed_q[idx_s1] && acc_q <= w_ext) begin
							// hit: remove entry, drop any read already in flight
							removed_q[idx_s1] <= 1'b1;
							total_q <= (total_q > w_ext) ? total_q - w_ext : '0;
							issue_q <= 1'b0;
							vld_s1  <= 1'b0;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							rsp_q   <= '{status: ST_OK, selected_index: idx_s1,
								draws_remaining: pending_q};
						end else begin
							if (!removed_q[idx_s1]) begin
								acc_q <= acc_q - w_ext;
							end
							if (last_s1) begin
								issue_q <= 1'b0;
								vld_s1  <= 1'b0;
								state_q <= S_IDLE;
								done_q  <= 1'b1;
								rsp_q   <= '{status: ST_BAD_INDEX, selected_index: '0,
									draws_remaining: pending_q};
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_vld_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q != S_IDLE)
		else $error("read data valid outside a walk");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> {1'b0, rd_addr_q} < n_use)
		else $error("walk address beyond entries in use");

	a_walk_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) != S_IDLE) |-> done_q)
		else $error("walk ended without a response");

	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done_q || busy))
		else $error("request neither answered nor in progress");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("response while still walking");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: weighted draw without replacement
// Directed and random command streams (weight writes, round starts, draws)
// against an in-bench roulette predictor; each answer is compared in order.
// ----------------------------------------------------------------------------
module testbench;
	import wdwr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_SHOWN   = 10;
	localparam int ITEM_TARGET = 1230;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic             start;
	req_t             req;
	logic             busy;
	logic             done;
	rsp_t             rsp;

	// predictor state
	logic [WEIGHT_W-1:0]    weights [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] taken = '0;
	int pool_total  = 0;
	int draws_left  = 0;
	int order_ptr   = 0;
	bit in_order    = 1'b0;
	int cfg_entries = 0;

	rsp_t due_answers [$];
	int   mismatches   = 0;
	int   sent_count   = 0;
	int   quiet_cycles = 0;
	int   burst_left   = 0;
	bit   paced        = 1'b1;

	weighted_draw_without_replacement u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t roulette_predict(req_t r);
		rsp_t a;
		int   n;
		int   k;
		int   rv;
		int   w;
		bit   hit;
		a = '0;
		n = (cfg_entries > MAX_ENTRIES) ? MAX_ENTRIES : cfg_entries;
		case (r.cmd)
			CMD_WRITE: begin
				if (int'(r.entry_index) >= n) begin
					a.status = ST_BAD_INDEX;
				end else begin
					weights[r.entry_index] = r.entry_weight;
					a.status = ST_OK;
				end
			end
			CMD_ROUND: begin
				if (int'(r.draw_count) > n) begin
					draws_left = 0;
					in_order   = 1'b0;
					a.status   = ST_COUNT_HIGH;
				end else begin
					taken      = '0;
					draws_left = int'(r.draw_count);
					order_ptr  = 0;
					in_order   = (int'(r.draw_count) == n);
					pool_total = 0;
					for (k = 0; k < n; k++) begin
						pool_total += int'(weights[k]);
						if (pool_total > int'(TOTAL_MAX))
							pool_total = int'(TOTAL_MAX);
					end
					a.status = ST_OK;
				end
			end
			CMD_DRAW: begin
				if (draws_left == 0) begin
					a.status = ST_NONE_DUE;
				end else begin
					draws_left--;
					if (in_order) begin
						k = order_ptr;
						order_ptr = (order_ptr + 1) % MAX_ENTRIES;
						if (k >= n) begin
							a.status = ST_BAD_INDEX;
						end else begin
							taken[k] = 1'b1;
							a.status = ST_OK;
							a.selected_index = IDX_W'(k);
						end
					end else begin
						rv  = int'(r.random_value);
						if (rv > pool_total)
							rv = pool_total;
						hit = 1'b0;
						a.status = ST_BAD_INDEX;
						for (k = 0; k < n && !hit; k++) begin
							if (!taken[k]) begin
								w = int'(weights[k]);
								if (rv <= w) begin
									hit = 1'b1;
									taken[k] = 1'b1;
									pool_total = (pool_total > w) ? pool_total - w : 0;
									a.status = ST_OK;
									a.selected_index = IDX_W'(k);
								end else begin
									rv -= w;
								end
							end
						end
					end
				end
			end
			default: a.status = ST_OK;
		endcase
		a.draws_remaining = CNT_W'(draws_left);
		return a;
	endfunction

	// fields the command does not use still carry random bits
	function automatic req_t noisy_req(logic [1:0] cmd);
		req_t r;
		r.cmd          = cmd;
		r.entry_index  = IDX_W'($urandom);
		r.entry_weight = WEIGHT_W'($urandom);
		r.draw_count   = CNT_W'($urandom);
		r.random_value = TOTAL_W'($urandom);
		return r;
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 255;
			default: return int'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_value();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 16383));
		return int'($urandom_range(0, pool_total));
	endfunction

	task automatic send_request(input req_t r);
		rsp_t a;
		int   gap;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		a = roulette_predict(r);
		due_answers.push_back(a);
		if (r.cmd != CMD_NOP)
			sent_count++;
		if (paced) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 11);
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_weight(input int idx, input int wt);
		req_t r;
		r = noisy_req(CMD_WRITE);
		r.entry_index  = IDX_W'(idx);
		r.entry_weight = WEIGHT_W'(wt);
		send_request(r);
	endtask

	task automatic start_round(input int cnt);
		req_t r;
		r = noisy_req(CMD_ROUND);
		r.draw_count = CNT_W'(cnt);
		send_request(r);
	endtask

	task automatic draw_one(input int rnd);
		req_t r;
		r = noisy_req(CMD_DRAW);
		r.random_value = TOTAL_W'(rnd);
		send_request(r);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (due_answers.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic set_entries(input int v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_entries = v;
	endtask

	// nothing in use: writes refused, empty round, oversize round, idle draw, no-op
	task automatic test_empty_table();
		write_weight(0, 255);
		start_round(0);
		start_round(127);
		draw_one(0);
		send_request(noisy_req(CMD_NOP));
	endtask

	task automatic test_weight_load();
		set_entries(4);
		write_weight(0, 255);
		write_weight(1, 0);
		write_weight(2, 1);
		write_weight(3, 128);
		write_weight(63, 77);
	endtask

	// count equal to entries in use: index order, random value ignored
	task automatic test_take_all();
		start_round(4);
		draw_one(16383);
		draw_one(0);
		draw_one(16383);
		draw_one(1);
		draw_one(5);
	endtask

	task automatic test_weighted_draws();
		start_round(3);
		draw_one(16383);
		draw_one(0);
		draw_one(1);
	endtask

	// register shrinks under a pending round, then a refused round cancels one
	task automatic test_mid_round_shrink();
		start_round(4);
		draw_one(0);
		set_entries(1);
		draw_one(0);
		set_entries(4);
		start_round(2);
		draw_one(0);
		set_entries(1);
		draw_one(0);
		start_round(1);
		start_round(2);
		draw_one(0);
	endtask

	task automatic test_random_rounds();
		int n;
		int v;
		int k;
		int cnt;
		int draws;
		set_entries(127);
		for (k = 0; k < MAX_ENTRIES; k++)
			write_weight(k, pick_weight());
		while (sent_count < ITEM_TARGET) begin
			paced = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0:       v = 0;
				1:       v = 1;
				2:       v = 2;
				3:       v = 64;
				4:       v = $urandom_range(65, 127);
				default: v = $urandom_range(1, 64);
			endcase
			set_entries(v);
			n = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
			repeat ($urandom_range(1, 4)) begin
				repeat ($urandom_range(0, 2)) begin
					if (n > 0 && $urandom_range(0, 3) != 0)
						write_weight($urandom_range(0, n - 1), pick_weight());
					else
						write_weight($urandom_range(0, 63), pick_weight());
				end
				case ($urandom_range(0, 9))
					0, 1:    cnt = n;
					2:       cnt = $urandom_range(n + 1, 127);
					default: cnt = $urandom_range(0, n);
				endcase
				start_round(cnt);
				// sometimes leave the round unfinished so the next setting hits it
				if ($urandom_range(0, 7) == 0)
					draws = $urandom_range(0, cnt);
				else
					draws = cnt + $urandom_range(0, 1);
				repeat (draws) begin
					if ($urandom_range(0, 11) == 0) begin
						case ($urandom_range(0, 2))
							0:       send_request(noisy_req(CMD_NOP));
							1:       write_weight($urandom_range(0, 63), pick_weight());
							default: start_round($urandom_range(0, 127));
						endcase
					end
					draw_one(pick_value());
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_answers
		rsp_t want;
		if (done === 1'b1) begin
			if (due_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected answer: status %0d index %0d left %0d",
						rsp.status, rsp.selected_index, rsp.draws_remaining);
			end else begin
				want = due_answers.pop_front();
				if (rsp.status !== want.status || rsp.selected_index !== want.selected_index ||
						rsp.draws_remaining !== want.draws_remaining) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("answer mismatch: expected status %0d index %0d left %0d, got status %0d index %0d left %0d",
							want.status, want.selected_index, want.draws_remaining,
							rsp.status, rsp.selected_index, rsp.draws_remaining);
				end
			end
		end
	end

	// watchdog: cycles with neither a request taken nor an answer given
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		start     = 1'b0;
		req       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_weight_load();
		test_take_all();
		test_weighted_draws();
		test_mid_round_shrink();
		test_random_rounds();
		settle();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && due_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
